// ===== design/dsvr_pkg.sv =====
package dsvr_pkg;

    localparam int EPOCH_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;
    localparam int DISP_BITS      = 4;
    localparam int OP_BITS        = 3;
    localparam int TIMEOUT_BITS   = 16;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [DISP_BITS-1:0]    MIN_DISP_RST = 4'd1;
    localparam logic [DISP_BITS-1:0]    MAX_DISP_RST = 4'd9;
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST  = 16'd3000;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_WAIT    = 3'd1,
        PH_RESTORE = 3'd2,
        PH_OK      = 3'd3,
        PH_FAIL    = 3'd4
    } t_phase;

    typedef enum logic [OP_BITS-1:0] {
        OP_REQUEST = 3'd0,
        OP_FRAME   = 3'd1,
        OP_FRESH   = 3'd2,
        OP_TICK    = 3'd3,
        OP_CANCEL  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        OC_SUCCESS     = 3'd0,
        OC_RESTORED    = 3'd1,
        OC_BOTH_FAILED = 3'd2,
        OC_TIMEOUT     = 3'd3,
        OC_CANCELLED   = 3'd4
    } t_outcome;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MIN_DISP = 2'd0,
        CFG_MAX_DISP = 2'd1,
        CFG_TIMEOUT  = 2'd2
    } t_cfg_idx;

    // control part of the verifier state
    typedef struct packed {
        t_phase               phase;
        logic [DISP_BITS-1:0] requested;
        logic [DISP_BITS-1:0] previous;
        logic [DISP_BITS-1:0] confirmed;
        logic                 restore_tried;
        logic                 gate_queued;
    } t_ctrl;

    // per-transaction result flags
    typedef struct packed {
        logic                 accepted;
        logic                 send_valid;
        logic [DISP_BITS-1:0] send_display;
        logic                 done;
        t_outcome             outcome;
    } t_flags;

endpackage

// ===== design/display_switch_verify_with_rollback_unit.sv =====
// an input transaction reaches the master side via the input and result registers
// one transaction per cycle unless stalled; state update is a single registered pass
// stalls on the master side hold the result register and back up into the input register
// reset: synchronous, active low; clears all verifier state, phase idle, gate disarmed,
// and loads the configuration defaults (min display 1, max display 9, timeout 3000 ms)
module display_switch_verify_with_rollback_unit #(
    parameter int EPOCH_BITS = dsvr_pkg::EPOCH_BITS_DEF,
    parameter int TIME_BITS  = dsvr_pkg::TIME_BITS_DEF,
    localparam int IN_RAW    = dsvr_pkg::DISP_BITS + EPOCH_BITS + TIME_BITS + 2,
    localparam int IN_W      = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW   = 2 * dsvr_pkg::DISP_BITS + dsvr_pkg::DISP_BITS
                               + 2 * EPOCH_BITS + 9,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // display, epoch_tag, now_ms, send_ok, enqueue_ok
    input  logic [IN_W-1:0]                    s_axis_tdata,
    // operation
    input  logic [dsvr_pkg::OP_BITS-1:0]       s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // accepted, send_valid, send_display, frame_tag, done_res, outcome,
    // phase_now, pending_display, last_display, current_epoch
    output logic [OUT_W-1:0]                   m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dsvr_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [dsvr_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import dsvr_pkg::*;

    localparam int TAG_LO = DISP_BITS;
    localparam int NOW_LO = TAG_LO + EPOCH_BITS;
    localparam int SOK_B  = NOW_LO + TIME_BITS;
    localparam int EOK_B  = SOK_B + 1;

    logic [DISP_BITS-1:0]    r_min_disp;
    logic [DISP_BITS-1:0]    r_max_disp;
    logic [TIMEOUT_BITS-1:0] r_timeout;

    logic                    r_in_valid;
    logic [OP_BITS-1:0]      r_in_op;
    logic [DISP_BITS-1:0]    r_in_display;
    logic [EPOCH_BITS-1:0]   r_in_tag;
    logic [TIME_BITS-1:0]    r_in_now;
    logic                    r_in_send_ok;
    logic                    r_in_enq_ok;

    t_ctrl                   r_ctrl;
    logic [EPOCH_BITS-1:0]   r_armed_epoch;
    logic [EPOCH_BITS-1:0]   r_epoch_cnt;
    logic [TIME_BITS-1:0]    r_deadline;
    logic [EPOCH_BITS-1:0]   r_gate_epoch;

    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;

    t_ctrl                   n_ctrl;
    logic [EPOCH_BITS-1:0]   n_armed_epoch;
    logic [EPOCH_BITS-1:0]   n_epoch_cnt;
    logic [TIME_BITS-1:0]    n_deadline;
    logic [EPOCH_BITS-1:0]   n_gate_epoch;
    t_flags                  n_flags;
    logic [EPOCH_BITS-1:0]   n_frame_tag;
    logic [DISP_BITS-1:0]    n_pending;
    logic [OUT_W-1:0]        n_out_data;

    logic                    advance;
    logic                    in_take;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_disp <= MIN_DISP_RST;
            r_max_disp <= MAX_DISP_RST;
            r_timeout  <= TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_DISP: r_min_disp <= i_cfg_data[DISP_BITS-1:0];
                CFG_MAX_DISP: r_max_disp <= i_cfg_data[DISP_BITS-1:0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[TIMEOUT_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op      <= s_axis_tuser;
            r_in_display <= s_axis_tdata[DISP_BITS-1:0];
            r_in_tag     <= s_axis_tdata[NOW_LO-1:TAG_LO];
            r_in_now     <= s_axis_tdata[SOK_B-1:NOW_LO];
            r_in_send_ok <= s_axis_tdata[SOK_B];
            r_in_enq_ok  <= s_axis_tdata[EOK_B];
        end
    end

    dsvr_step #(
        .EPOCH_BITS (EPOCH_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_step (
        .i_op          (r_in_op),
        .i_display     (r_in_display),
        .i_epoch_tag   (r_in_tag),
        .i_now_ms      (r_in_now),
        .i_send_ok     (r_in_send_ok),
        .i_enqueue_ok  (r_in_enq_ok),
        .i_min_disp    (r_min_disp),
        .i_max_disp    (r_max_disp),
        .i_timeout     (r_timeout),
        .i_ctrl        (r_ctrl),
        .i_armed_epoch (r_armed_epoch),
        .i_epoch_cnt   (r_epoch_cnt),
        .i_deadline    (r_deadline),
        .i_gate_epoch  (r_gate_epoch),
        .o_ctrl        (n_ctrl),
        .o_armed_epoch (n_armed_epoch),
        .o_epoch_cnt   (n_epoch_cnt),
        .o_deadline    (n_deadline),
        .o_gate_epoch  (n_gate_epoch),
        .o_flags       (n_flags),
        .o_frame_tag   (n_frame_tag),
        .o_pending     (n_pending)
    );

    assign n_out_data = OUT_W'({n_armed_epoch,
                                n_ctrl.confirmed, n_pending, n_ctrl.phase,
                                n_flags.outcome, n_flags.done, n_frame_tag,
                                n_flags.send_display, n_flags.send_valid,
                                n_flags.accepted});

    // verifier state advances once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl        <= '{phase: PH_IDLE, default: '0};
            r_armed_epoch <= '0;
            r_epoch_cnt   <= '0;
            r_deadline    <= '0;
            r_gate_epoch  <= '0;
        end else if (advance) begin
            r_ctrl        <= n_ctrl;
            r_armed_epoch <= n_armed_epoch;
            r_epoch_cnt   <= n_epoch_cnt;
            r_deadline    <= n_deadline;
            r_gate_epoch  <= n_gate_epoch;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== design/dsvr_step.sv =====
module dsvr_step #(
    parameter int EPOCH_BITS = dsvr_pkg::EPOCH_BITS_DEF,
    parameter int TIME_BITS  = dsvr_pkg::TIME_BITS_DEF
) (
    input  logic [dsvr_pkg::OP_BITS-1:0]      i_op,
    input  logic [dsvr_pkg::DISP_BITS-1:0]    i_display,
    input  logic [EPOCH_BITS-1:0]             i_epoch_tag,
    input  logic [TIME_BITS-1:0]              i_now_ms,
    input  logic                              i_send_ok,
    input  logic                              i_enqueue_ok,
    input  logic [dsvr_pkg::DISP_BITS-1:0]    i_min_disp,
    input  logic [dsvr_pkg::DISP_BITS-1:0]    i_max_disp,
    input  logic [dsvr_pkg::TIMEOUT_BITS-1:0] i_timeout,
    input  dsvr_pkg::t_ctrl                   i_ctrl,
    input  logic [EPOCH_BITS-1:0]             i_armed_epoch,
    input  logic [EPOCH_BITS-1:0]             i_epoch_cnt,
    input  logic [TIME_BITS-1:0]              i_deadline,
    input  logic [EPOCH_BITS-1:0]             i_gate_epoch,
    output dsvr_pkg::t_ctrl                   o_ctrl,
    output logic [EPOCH_BITS-1:0]             o_armed_epoch,
    output logic [EPOCH_BITS-1:0]             o_epoch_cnt,
    output logic [TIME_BITS-1:0]              o_deadline,
    output logic [EPOCH_BITS-1:0]             o_gate_epoch,
    output dsvr_pkg::t_flags                  o_flags,
    output logic [EPOCH_BITS-1:0]             o_frame_tag,
    output logic [dsvr_pkg::DISP_BITS-1:0]    o_pending
);
    import dsvr_pkg::*;

    logic                  active;
    logic [EPOCH_BITS-1:0] ep_inc;
    logic [EPOCH_BITS-1:0] ep_fresh;
    logic [TIME_BITS-1:0]  dl_sum;

    logic req_go, req_arm, req_fail;
    logic frm_go, frm_q;
    logic frs_go, frs_ok;
    logic tk_go, tk_try, tk_rearm, tk_rfail, tk_tmo, tk_restfail;
    logic cn_go;
    logic fin;

    assign active   = (i_ctrl.phase == PH_WAIT) || (i_ctrl.phase == PH_RESTORE);
    assign ep_inc   = i_epoch_cnt + EPOCH_BITS'(1);
    // the epoch counter skips zero on wrap
    assign ep_fresh = (ep_inc == '0) ? EPOCH_BITS'(1) : ep_inc;
    assign dl_sum   = i_now_ms + TIME_BITS'(i_timeout);

    // event decode
    always_comb begin
        req_go      = 1'b0;
        frm_go      = 1'b0;
        frs_go      = 1'b0;
        tk_go       = 1'b0;
        cn_go       = 1'b0;
        case (t_op'(i_op))
            OP_REQUEST: req_go = (i_display >= i_min_disp) && (i_display <= i_max_disp)
                                 && !active;
            OP_FRAME:   frm_go = (i_gate_epoch != '0) && !i_ctrl.gate_queued;
            OP_FRESH:   frs_go = active && (i_epoch_tag != '0)
                                 && (i_epoch_tag == i_armed_epoch)
                                 && (i_gate_epoch == i_epoch_tag) && i_ctrl.gate_queued;
            OP_TICK:    tk_go  = active && (i_now_ms >= i_deadline);
            OP_CANCEL:  cn_go  = active;
            default:    ;
        endcase
        req_arm     = req_go && i_send_ok;
        req_fail    = req_go && !i_send_ok;
        frm_q       = frm_go && i_enqueue_ok;
        frs_ok      = frs_go && (i_ctrl.phase == PH_WAIT);
        tk_try      = tk_go && (i_ctrl.phase == PH_WAIT) && !i_ctrl.restore_tried
                      && (i_ctrl.previous != '0) && (i_ctrl.previous != i_ctrl.requested);
        tk_rearm    = tk_try && i_send_ok;
        tk_rfail    = tk_try && !i_send_ok;
        tk_tmo      = tk_go && (i_ctrl.phase == PH_WAIT) && !tk_try;
        tk_restfail = tk_go && (i_ctrl.phase == PH_RESTORE);
        fin         = frs_go || tk_rfail || tk_tmo || tk_restfail || cn_go;
    end

    // next state
    always_comb begin
        o_ctrl        = i_ctrl;
        o_armed_epoch = i_armed_epoch;
        o_epoch_cnt   = i_epoch_cnt;
        o_deadline    = i_deadline;
        o_gate_epoch  = i_gate_epoch;
        if (req_go) begin
            o_ctrl.requested     = i_display;
            o_ctrl.previous      = i_ctrl.confirmed;
            o_ctrl.restore_tried = 1'b0;
        end
        if (tk_rearm) begin
            o_ctrl.restore_tried = 1'b1;
        end
        if (req_arm || tk_rearm) begin
            o_epoch_cnt        = ep_fresh;
            o_armed_epoch      = ep_fresh;
            o_gate_epoch       = ep_fresh;
            o_deadline         = dl_sum;
            o_ctrl.gate_queued = 1'b0;
            o_ctrl.phase       = req_arm ? PH_WAIT : PH_RESTORE;
        end
        if (req_fail) begin
            o_gate_epoch       = '0;
            o_ctrl.gate_queued = 1'b0;
            o_ctrl.requested   = '0;
            o_ctrl.previous    = '0;
            o_deadline         = '0;
            o_armed_epoch      = '0;
            o_ctrl.phase       = PH_FAIL;
        end
        if (frm_go) begin
            o_ctrl.gate_queued = i_enqueue_ok;
        end
        if (fin) begin
            if (frs_ok) begin
                o_ctrl.confirmed = i_ctrl.requested;
            end
            o_gate_epoch         = '0;
            o_ctrl.gate_queued   = 1'b0;
            o_ctrl.phase         = frs_ok ? PH_OK : PH_FAIL;
            o_deadline           = '0;
            o_ctrl.requested     = '0;
            o_ctrl.previous      = '0;
            o_ctrl.restore_tried = 1'b0;
            o_armed_epoch        = '0;
        end
    end

    // result fields
    always_comb begin
        o_flags.accepted     = req_arm || frm_q || frs_go || tk_go || cn_go;
        o_flags.send_valid   = req_go || tk_try;
        o_flags.send_display = req_go ? i_display :
                               (tk_try ? i_ctrl.previous : '0);
        o_flags.done         = fin;
        if (frs_ok) begin
            o_flags.outcome = OC_SUCCESS;
        end else if (frs_go) begin
            o_flags.outcome = OC_RESTORED;
        end else if (tk_rfail || tk_restfail) begin
            o_flags.outcome = OC_BOTH_FAILED;
        end else if (tk_tmo) begin
            o_flags.outcome = OC_TIMEOUT;
        end else if (cn_go) begin
            o_flags.outcome = OC_CANCELLED;
        end else begin
            o_flags.outcome = OC_SUCCESS;
        end
        o_frame_tag = frm_go ? i_gate_epoch : '0;
        case (o_ctrl.phase)
            PH_RESTORE: o_pending = o_ctrl.previous;
            PH_WAIT:    o_pending = o_ctrl.requested;
            default:    o_pending = '0;
        endcase
    end

endmodule

// ===== design/dsvr_checker.sv =====
module dsvr_checker #(
    parameter int EPOCH_BITS = dsvr_pkg::EPOCH_BITS_DEF,
    parameter int TIME_BITS  = dsvr_pkg::TIME_BITS_DEF,
    localparam int OUT_RAW   = 3 * dsvr_pkg::DISP_BITS + 2 * EPOCH_BITS + 9,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);
    import dsvr_pkg::*;

    localparam int DONE_B = 2 + DISP_BITS + EPOCH_BITS;
    localparam int OC_LO  = DONE_B + 1;
    localparam int PH_LO  = OC_LO + 3;
    localparam int PD_LO  = PH_LO + 3;
    localparam int EP_LO  = PD_LO + 2 * DISP_BITS;

    logic                 done_res;
    logic [2:0]           outcome;
    logic [2:0]           phase_now;
    logic [DISP_BITS-1:0] pending;
    logic                 epoch_live;
    logic                 phase_active;

    assign done_res     = m_axis_tdata[DONE_B];
    assign outcome      = m_axis_tdata[OC_LO+2:OC_LO];
    assign phase_now    = m_axis_tdata[PH_LO+2:PH_LO];
    assign pending      = m_axis_tdata[PD_LO+DISP_BITS-1:PD_LO];
    assign epoch_live   = m_axis_tdata[EP_LO+EPOCH_BITS-1:EP_LO] != '0;
    assign phase_active = (phase_now == PH_WAIT) || (phase_now == PH_RESTORE);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && done_res |-> (phase_now == PH_OK) || (phase_now == PH_FAIL))
        else $error("completion without a final phase");

    a_outcome_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !done_res |-> outcome == OC_SUCCESS)
        else $error("outcome set without completion");

    a_epoch_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> epoch_live == phase_active)
        else $error("armed epoch disagrees with phase");

    a_pending_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !phase_active |-> pending == '0)
        else $error("pending display outside an active request");

endmodule

bind display_switch_verify_with_rollback_unit dsvr_checker #(
    .EPOCH_BITS (EPOCH_BITS),
    .TIME_BITS  (TIME_BITS)
) u_dsvr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
